@@ rtl/itoa_pkg.sv @@
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int COUNT_W    = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(NUM_DIGITS);
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    bcd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

@@ rtl/itoa_if.sv @@
`timescale 1ns / 1ps

interface itoa_in_if import itoa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text.
// Input channel "in" carries one signed value per transfer. Output channel
// "out" carries the text one character per transfer, most significant first:
// a '-' for a negative value, then the digits without leading zeros; the
// final character has last set. One value gives 1 to 11 output transfers.
// Steps: the value is taken while idle, converted to BCD one input bit per
// step by one shift-and-adjust unit, then leading zero digits are dropped at
// one per cycle (up to 9), then one character is loaded per cycle into the
// output register whenever that register is free. A new value is taken only
// after the last character of the previous one has been loaded.
// in.ready is high only while the block is idle. The output register lets
// the next value be taken while the last character still waits.
// When the receiver stalls, emission pauses and the held character stays.
// Synchronous reset returns the block to idle and empties the output
// register; no conversion in progress survives.
module signed_int_to_decimal_ascii_top import itoa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  itoa_in_if.sink       in,
  itoa_out_if.source    out
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    CONV  = 5'b00010,
    SKIP  = 5'b00100,
    SIGN  = 5'b01000,
    DIGIT = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [VALUE_W-1:0]  mag, mag_next;
  logic [BCD_W-1:0]    bcd, bcd_next;
  logic [BCD_W-1:0]    bcd_adj;
  logic [STEP_W-1:0]   step, step_next;
  logic [COUNT_W-1:0]  ndig, ndig_next;
  logic                neg, neg_next;
  logic                out_free;
  logic                load;
  logic [CHAR_W-1:0]   char_next;
  logic                last_next;

  assign in.ready = (state == IDLE);
  assign out_free = !out.valid || out.ready;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = bcd_adjust(bcd[4*i +: 4]);
    end
  end

  always_comb begin
    state_next = state;
    mag_next   = mag;
    bcd_next   = bcd;
    step_next  = step;
    ndig_next  = ndig;
    neg_next   = neg;
    load       = 1'b0;
    char_next  = CHAR_ZERO;
    last_next  = 1'b0;
    case (state)
      IDLE: begin
        if (in.valid) begin
          neg_next   = in.value[VALUE_W-1];
          mag_next   = in.value[VALUE_W-1] ? (~in.value) + VALUE_W'(1) : in.value;
          bcd_next   = '0;
          step_next  = STEP_W'(VALUE_W - 1);
          ndig_next  = COUNT_FULL;
          state_next = CONV;
        end
      end
      CONV: begin
        bcd_next  = {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
        mag_next  = {mag[VALUE_W-2:0], 1'b0};
        step_next = step - STEP_W'(1);
        if (step == '0) begin
          state_next = SKIP;
        end
      end
      SKIP: begin
        if (bcd[BCD_W-1 -: 4] == 4'd0 && ndig != COUNT_ONE) begin
          bcd_next  = {bcd[BCD_W-5:0], 4'd0};
          ndig_next = ndig - COUNT_ONE;
        end else begin
          state_next = neg ? SIGN : DIGIT;
        end
      end
      SIGN: begin
        if (out_free) begin
          load       = 1'b1;
          char_next  = CHAR_MINUS;
          state_next = DIGIT;
        end
      end
      DIGIT: begin
        if (out_free) begin
          load      = 1'b1;
          char_next = CHAR_ZERO + CHAR_W'(bcd[BCD_W-1 -: 4]);
          last_next = (ndig == COUNT_ONE);
          bcd_next  = {bcd[BCD_W-5:0], 4'd0};
          ndig_next = ndig - COUNT_ONE;
          if (ndig == COUNT_ONE) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag  <= mag_next;
    bcd  <= bcd_next;
    step <= step_next;
    ndig <= ndig_next;
    neg  <= neg_next;
    if (load) begin
      out.character <= char_next;
      out.last      <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> state == CONV)
    else $error("transfer in did not start conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.character == CHAR_MINUS |-> !out.last)
    else $error("minus sign marked last");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.last |-> out.character >= CHAR_ZERO && out.character <= 8'd57)
    else $error("last character is not a digit");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == DIGIT || state == SKIP || state == SIGN |-> ndig != '0)
    else $error("digit count ran out");

  a_conv_length: assert property (@(posedge clk) disable iff (rst)
    state == CONV && step == '0 |=> state == SKIP)
    else $error("conversion did not end after the last step");
`endif

endmodule
